// ----- hw/rtl/apdg_pkg.sv -----
// ----------------------------------------------------------------------------
// apdg_pkg
// Shared types and constants for the audio packet deframer with makeup gain.
// ----------------------------------------------------------------------------
`default_nettype none

package apdg_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned GAIN_W   = 20;
  localparam int unsigned RAW_W    = 32;
  localparam int unsigned PROD_W   = RAW_W + GAIN_W;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned HCNT_W   = 6;
  localparam int unsigned PHASE_W  = 2;

  localparam logic [31:0]       HDR_MAGIC  = 32'h4553_5032;
  localparam logic [HCNT_W-1:0] HDR_LAST   = HCNT_W'(33);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

  // header byte offsets
  localparam logic [HCNT_W-1:0] OFS_SEQ      = HCNT_W'(4);
  localparam logic [HCNT_W-1:0] OFS_INDEX    = HCNT_W'(8);
  localparam logic [HCNT_W-1:0] OFS_TSTAMP   = HCNT_W'(16);
  localparam logic [HCNT_W-1:0] OFS_FRAMES_L = HCNT_W'(24);
  localparam logic [HCNT_W-1:0] OFS_FRAMES_H = HCNT_W'(25);
  localparam logic [HCNT_W-1:0] OFS_CHANNELS = HCNT_W'(26);
  localparam logic [HCNT_W-1:0] OFS_BPS      = HCNT_W'(27);

  // parse phases
  localparam logic [PHASE_W-1:0] PH_HEADER  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 2'd1;
  localparam logic [PHASE_W-1:0] PH_HALTED  = 2'd2;

  // event kinds
  localparam logic [KIND_W-1:0] EV_SAMPLE    = 2'd0;
  localparam logic [KIND_W-1:0] EV_PKT_END   = 2'd1;
  localparam logic [KIND_W-1:0] EV_BAD_MAGIC = 2'd2;
  localparam logic [KIND_W-1:0] EV_EMPTY     = 2'd3;

  localparam logic [31:0] SAT_POS_LIM = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG_LIM = 32'h8000_0000;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(2048);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              done;
    logic [31:0]       seq;
    logic [63:0]       high_idx;
    logic [31:0]       written;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/audio_packet_deframer_gain_core.sv -----
// ----------------------------------------------------------------------------
// audio_packet_deframer_gain_core
// Byte-serial packet deframer: header parse, int32 sample assembly, Q8.12
// makeup gain with round half away from zero, saturation and 24-bit output.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle, back to back; the input stalls only while
// both the product register and the output register hold undelivered events
// and out_ready is low. When a byte that produces an event is accepted, its
// 32x20 gain product and status land in the first register; once the output
// register is free, the rounded, saturated sample and status words move there
// with out_valid high. Halted bytes, quiet payload bytes and header bytes but
// the last (which may flag bad magic or an empty packet) give no output beat.
// The gain register is written through the cfg port, which is always ready.
`default_nettype none

module audio_packet_deframer_gain_core (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_stream_byte,
  input  wire logic        in_new_connection,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [19:0] cfg_gain_q8_12,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_event_kind,
  output logic [23:0]      out_sample_out,
  output logic             out_packet_done,
  output logic [31:0]      out_seq_status,
  output logic [63:0]      out_highest_index_status,
  output logic [31:0]      out_samples_written_status
);

  // configuration
  logic [apdg_pkg::GAIN_W-1:0] gain_r;

  // parse state
  logic [apdg_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [apdg_pkg::HCNT_W-1:0]  hcnt_r, hcnt_nxt;
  logic [31:0] magic_r, magic_nxt;
  logic [31:0] seq_hold_r, seq_hold_nxt;
  logic [63:0] first_r, first_nxt;
  logic [15:0] frames_r, frames_nxt;
  logic [7:0]  chans_r, chans_nxt;
  logic [7:0]  bps_r, bps_nxt;
  logic [23:0] fc_r, fc_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [23:0] asm_r, asm_nxt;
  logic [31:0] last_seq_r, last_seq_nxt;
  logic [63:0] high_idx_r, high_idx_nxt;
  logic [31:0] written_r, written_nxt;

  // first stage
  logic                         s1_valid_r;
  apdg_pkg::status_t            s1_stat_r, s1_stat_nxt;
  logic [apdg_pkg::PROD_W-1:0]  s1_prod_r;
  logic                         res_fire;

  // output stage
  logic                         out_valid_r;
  apdg_pkg::status_t            out_stat_r;
  logic [apdg_pkg::SAMPLE_W-1:0] out_sample_r;

  logic in_fire, out_free, s1_move;

  logic [apdg_pkg::PHASE_W-1:0] phase_eff;
  logic [apdg_pkg::HCNT_W-1:0]  k;
  logic [31:0]                  pay_len;
  logic [31:0]                  raw;
  logic signed [apdg_pkg::PROD_W-1:0] prod;
  logic                         pay_done;

  assign out_free  = !out_valid_r || out_ready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign pay_len = 32'(fc_r) * 32'(bps_r);
  assign raw     = {in_stream_byte, asm_r};
  assign prod    = $signed(raw) * $signed(gain_r);
  assign pay_done = (rem_r == 32'd1);

  always_comb begin
    phase_eff = in_new_connection ? apdg_pkg::PH_HEADER : phase_r;
    k         = in_new_connection ? '0 : hcnt_r;

    phase_nxt    = phase_eff;
    hcnt_nxt     = k;
    magic_nxt    = magic_r;
    seq_hold_nxt = seq_hold_r;
    first_nxt    = first_r;
    frames_nxt   = frames_r;
    chans_nxt    = chans_r;
    bps_nxt      = bps_r;
    fc_nxt       = fc_r;
    rem_nxt      = rem_r;
    pos_nxt      = pos_r;
    asm_nxt      = asm_r;
    last_seq_nxt = last_seq_r;
    high_idx_nxt = high_idx_r;
    written_nxt  = written_r;

    res_fire          = 1'b0;
    s1_stat_nxt.kind  = apdg_pkg::EV_SAMPLE;
    s1_stat_nxt.done  = 1'b0;

    case (phase_eff)
      apdg_pkg::PH_HEADER: begin
        if (k < apdg_pkg::OFS_SEQ) begin
          magic_nxt[8*k[1:0] +: 8] = in_stream_byte;
        end else if (k < apdg_pkg::OFS_INDEX) begin
          seq_hold_nxt[8*k[1:0] +: 8] = in_stream_byte;
        end else if (k < apdg_pkg::OFS_TSTAMP) begin
          first_nxt[8*k[2:0] +: 8] = in_stream_byte;
        end else if (k == apdg_pkg::OFS_FRAMES_L) begin
          frames_nxt[7:0] = in_stream_byte;
        end else if (k == apdg_pkg::OFS_FRAMES_H) begin
          frames_nxt[15:8] = in_stream_byte;
        end else if (k == apdg_pkg::OFS_CHANNELS) begin
          chans_nxt = in_stream_byte;
        end else if (k == apdg_pkg::OFS_BPS) begin
          bps_nxt = in_stream_byte;
          // frames and channels are both in place by now
          fc_nxt  = 24'(frames_r) * 24'(chans_r);
        end

        if (k != apdg_pkg::HDR_LAST) begin
          hcnt_nxt = k + 1'b1;
        end else begin
          hcnt_nxt = '0;
          if (magic_r != apdg_pkg::HDR_MAGIC) begin
            phase_nxt        = apdg_pkg::PH_HALTED;
            res_fire         = 1'b1;
            s1_stat_nxt.kind = apdg_pkg::EV_BAD_MAGIC;
          end else begin
            rem_nxt = pay_len;
            if (pay_len == '0) begin
              res_fire         = 1'b1;
              s1_stat_nxt.kind = apdg_pkg::EV_EMPTY;
            end else begin
              pos_nxt   = '0;
              asm_nxt   = '0;
              phase_nxt = apdg_pkg::PH_PAYLOAD;
            end
          end
        end
      end

      apdg_pkg::PH_PAYLOAD: begin
        pos_nxt = pos_r + 1'b1;
        rem_nxt = rem_r - 1'b1;
        if (pos_r < {14'd0, frames_r, 2'b00}) begin
          if (pos_r[1:0] != 2'd3) begin
            asm_nxt[8*pos_r[1:0] +: 8] = in_stream_byte;
          end else begin
            res_fire         = 1'b1;
            s1_stat_nxt.kind = apdg_pkg::EV_SAMPLE;
          end
        end
        if (pay_done) begin
          last_seq_nxt = seq_hold_r;
          high_idx_nxt = first_r + 64'(frames_r) - 64'd1;
          written_nxt  = written_r + 32'(frames_r);
          phase_nxt    = apdg_pkg::PH_HEADER;
          hcnt_nxt     = '0;
          s1_stat_nxt.done = 1'b1;
          if (!res_fire) begin
            res_fire         = 1'b1;
            s1_stat_nxt.kind = apdg_pkg::EV_PKT_END;
          end
        end
      end

      default: begin
        // halted: bytes are dropped until a new connection
      end
    endcase

    s1_stat_nxt.seq      = last_seq_nxt;
    s1_stat_nxt.high_idx = high_idx_nxt;
    s1_stat_nxt.written  = written_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= apdg_pkg::GAIN_RESET;
      phase_r    <= apdg_pkg::PH_HEADER;
      hcnt_r     <= '0;
      magic_r    <= '0;
      seq_hold_r <= '0;
      first_r    <= '0;
      frames_r   <= '0;
      chans_r    <= '0;
      bps_r      <= '0;
      fc_r       <= '0;
      rem_r      <= '0;
      pos_r      <= '0;
      asm_r      <= '0;
      last_seq_r <= '0;
      high_idx_r <= '0;
      written_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gain_r <= cfg_gain_q8_12;
      end
      if (in_fire) begin
        phase_r    <= phase_nxt;
        hcnt_r     <= hcnt_nxt;
        magic_r    <= magic_nxt;
        seq_hold_r <= seq_hold_nxt;
        first_r    <= first_nxt;
        frames_r   <= frames_nxt;
        chans_r    <= chans_nxt;
        bps_r      <= bps_nxt;
        fc_r       <= fc_nxt;
        rem_r      <= rem_nxt;
        pos_r      <= pos_nxt;
        asm_r      <= asm_nxt;
        last_seq_r <= last_seq_nxt;
        high_idx_r <= high_idx_nxt;
        written_r  <= written_nxt;
      end
    end
  end

  // stage 1: raw gain product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_fire && res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_fire) begin
      s1_stat_r <= s1_stat_nxt;
      s1_prod_r <= prod;
    end
  end

  // stage 2: round half away from zero, saturate, drop 8 LSBs
  logic                        p_neg;
  logic [apdg_pkg::PROD_W-1:0] p_mag_rnd;
  logic [39:0]                 p_q;
  logic [31:0]                 p_sat;
  logic [apdg_pkg::SAMPLE_W-1:0] p_sample;

  always_comb begin
    p_neg = s1_prod_r[apdg_pkg::PROD_W-1];
    // |p| + 2048 folded into one add for negative products
    p_mag_rnd = p_neg ? (~s1_prod_r + apdg_pkg::ROUND_HALF + 1'b1)
                      : (s1_prod_r + apdg_pkg::ROUND_HALF);
    p_q = p_mag_rnd[apdg_pkg::PROD_W-1:12];
    if (!p_neg) begin
      p_sat = (p_q > 40'(apdg_pkg::SAT_POS_LIM)) ? apdg_pkg::SAT_POS_LIM : p_q[31:0];
    end else begin
      p_sat = (p_q > 40'(apdg_pkg::SAT_NEG_LIM)) ? apdg_pkg::SAT_NEG_LIM
                                                 : (32'd0 - p_q[31:0]);
    end
    p_sample = (s1_stat_r.kind == apdg_pkg::EV_SAMPLE) ? p_sat[31:8] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_stat_r   <= s1_stat_r;
      out_sample_r <= p_sample;
    end
  end

  assign out_valid                  = out_valid_r;
  assign out_event_kind             = out_stat_r.kind;
  assign out_sample_out             = out_sample_r;
  assign out_packet_done            = out_stat_r.done;
  assign out_seq_status             = out_stat_r.seq;
  assign out_highest_index_status   = out_stat_r.high_idx;
  assign out_samples_written_status = out_stat_r.written;

endmodule

`default_nettype wire

// ----- dv/audio_packet_deframer_gain_core_tb.sv -----
// ----------------------------------------------------------------------------
// audio_packet_deframer_gain_core_tb
// Self-checking bench for the packet deframer: drives byte beats through the
// input handshake, predicts every event with a local deframer and gain model,
// and checks each output beat field by field. Covers corner samples under
// extreme gains, payload shapes, empty packets, bad magic with halt,
// new-connection restarts, index wrap, and randomized packet streams under
// varying back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_packet_deframer_gain_core_tb;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [apdg_pkg::KIND_W-1:0]   kind;
    logic [apdg_pkg::SAMPLE_W-1:0] sample;
    logic                          done;
    logic [31:0]                   seq;
    logic [63:0]                   high_idx;
    logic [31:0]                   written;
  } deframe_event_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_stream_byte = 8'h00;
  logic        in_new_connection = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [19:0] cfg_gain_q8_12 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_event_kind;
  logic [23:0] out_sample_out;
  logic        out_packet_done;
  logic [31:0] out_seq_status;
  logic [63:0] out_highest_index_status;
  logic [31:0] out_samples_written_status;

  audio_packet_deframer_gain_core dut (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .in_valid                   (in_valid),
    .in_ready                   (in_ready),
    .in_stream_byte             (in_stream_byte),
    .in_new_connection          (in_new_connection),
    .cfg_valid                  (cfg_valid),
    .cfg_ready                  (cfg_ready),
    .cfg_gain_q8_12             (cfg_gain_q8_12),
    .out_valid                  (out_valid),
    .out_ready                  (out_ready),
    .out_event_kind             (out_event_kind),
    .out_sample_out             (out_sample_out),
    .out_packet_done            (out_packet_done),
    .out_seq_status             (out_seq_status),
    .out_highest_index_status   (out_highest_index_status),
    .out_samples_written_status (out_samples_written_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  int tx_idle_pct = 17;
  int rx_idle_pct = 86;
  int errors = 0;
  int live_bytes = 0;
  int stall_cycles = 0;

  deframe_event_t pending_events[$];

  // deframer shadow state
  logic [19:0]                  gain_m = apdg_pkg::GAIN_RESET;
  logic [apdg_pkg::PHASE_W-1:0] parse_ph = apdg_pkg::PH_HEADER;
  logic [apdg_pkg::HCNT_W-1:0]  hdr_count = '0;
  logic [31:0]        magic_acc = '0;
  logic [31:0]        seq_acc = '0;
  logic [63:0]        index_acc = '0;
  logic [15:0]        frames_acc = '0;
  logic [7:0]         chans_acc = '0;
  logic [7:0]         bps_acc = '0;
  logic [31:0]        bytes_left = '0;
  logic [31:0]        byte_pos = '0;
  logic [23:0]        partial_word = '0;
  logic [31:0]        last_seq_m = '0;
  logic [63:0]        high_idx_m = '0;
  logic [31:0]        written_m = '0;

  logic [31:0] corner_words [8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_01FF,
                                    32'hFFFF_FDFF, 32'h1234_5678};

  // gain, round half away from zero, clamp to int32, keep the top 24 bits
  function automatic logic [23:0] scale_to_24(input logic [31:0] raw);
    logic signed [63:0] prod;
    logic signed [63:0] mag;
    logic signed [63:0] r;
    prod = 64'(signed'(raw)) * 64'(signed'(gain_m));
    mag = (prod < 0) ? -prod : prod;
    mag = (mag + 64'sd2048) >>> 12;
    r = (prod < 0) ? -mag : mag;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:8];
  endfunction

  function automatic void post_event(input logic [1:0] kind, input logic [23:0] sample,
                                     input logic done);
    deframe_event_t ev;
    ev.kind = kind;
    ev.sample = sample;
    ev.done = done;
    ev.seq = last_seq_m;
    ev.high_idx = high_idx_m;
    ev.written = written_m;
    pending_events.insert(pending_events.size(), ev);
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, input logic nc);
    int kk;
    logic [31:0] pos;
    logic [1:0] lane;
    logic done;
    logic emit;
    logic [23:0] sample;
    if (nc) begin
      parse_ph = apdg_pkg::PH_HEADER;
      hdr_count = '0;
    end
    if (parse_ph != apdg_pkg::PH_HALTED) live_bytes++;
    if (parse_ph == apdg_pkg::PH_HEADER) begin
      kk = int'(hdr_count);
      if (kk < int'(apdg_pkg::OFS_SEQ)) magic_acc[8*kk +: 8] = b;
      else if (kk < int'(apdg_pkg::OFS_INDEX)) seq_acc[8*(kk-4) +: 8] = b;
      else if (kk < int'(apdg_pkg::OFS_TSTAMP)) index_acc[8*(kk-8) +: 8] = b;
      else if (kk == int'(apdg_pkg::OFS_FRAMES_L)) frames_acc[7:0] = b;
      else if (kk == int'(apdg_pkg::OFS_FRAMES_H)) frames_acc[15:8] = b;
      else if (kk == int'(apdg_pkg::OFS_CHANNELS)) chans_acc = b;
      else if (kk == int'(apdg_pkg::OFS_BPS)) bps_acc = b;
      if (hdr_count != apdg_pkg::HDR_LAST) begin
        hdr_count = hdr_count + 1'b1;
        return;
      end
      hdr_count = '0;
      if (magic_acc != apdg_pkg::HDR_MAGIC) begin
        parse_ph = apdg_pkg::PH_HALTED;
        post_event(apdg_pkg::EV_BAD_MAGIC, '0, 1'b0);
        return;
      end
      bytes_left = 32'(frames_acc) * 32'(chans_acc) * 32'(bps_acc);
      if (bytes_left == 0) begin
        post_event(apdg_pkg::EV_EMPTY, '0, 1'b0);
        return;
      end
      byte_pos = '0;
      partial_word = '0;
      parse_ph = apdg_pkg::PH_PAYLOAD;
      return;
    end
    if (parse_ph != apdg_pkg::PH_PAYLOAD) return;
    pos = byte_pos;
    byte_pos = pos + 1;
    bytes_left = bytes_left - 1;
    done = (bytes_left == 0);
    emit = 1'b0;
    sample = '0;
    if (pos < 32'(frames_acc) * 4) begin
      lane = pos[1:0];
      if (lane != 2'd3) partial_word[8*lane +: 8] = b;
      else begin
        sample = scale_to_24({b, partial_word});
        emit = 1'b1;
      end
    end
    if (done) begin
      last_seq_m = seq_acc;
      high_idx_m = index_acc + 64'(frames_acc) - 64'd1;
      written_m = written_m + 32'(frames_acc);
      parse_ph = apdg_pkg::PH_HEADER;
      hdr_count = '0;
    end
    if (emit) post_event(apdg_pkg::EV_SAMPLE, sample, done);
    else if (done) post_event(apdg_pkg::EV_PKT_END, '0, 1'b1);
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // output side: check accepted beats, then randomize ready for the next edge
  always @(posedge clk) begin
    deframe_event_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected output beat: expected none, got kind %0d sample 0x%0h",
                 $time, out_event_kind, out_sample_out);
        errors++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", want.kind, out_event_kind);
        check_field("sample_out", want.sample, out_sample_out);
        check_field("packet_done", want.done, out_packet_done);
        check_field("seq_status", want.seq, out_seq_status);
        check_field("highest_index_status", want.high_idx, out_highest_index_status);
        check_field("samples_written_status", want.written, out_samples_written_status);
      end
    end
    out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog timeout, %0d events outstanding", $time,
               pending_events.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic nc);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_stream_byte <= b;
    in_new_connection <= nc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_byte(b, nc);
  endtask

  // wait until every predicted event is out and the pipeline has emptied
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_gain(input logic [19:0] g);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_gain_q8_12 <= g;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    gain_m = g;
    cfg_valid <= 1'b0;
  endtask

  // sends the first len bytes of a header; timestamp and remaining unparsed bytes are random
  task automatic send_header(input logic [31:0] magic, input logic [31:0] seq,
                             input logic [63:0] first_idx, input logic [15:0] frames,
                             input logic [7:0] chans, input logic [7:0] bps,
                             input logic nc, input int len);
    logic [7:0] b;
    for (int k = 0; k < len; k++) begin
      b = 8'($urandom_range(255));
      if (k < int'(apdg_pkg::OFS_SEQ)) b = magic[8*k +: 8];
      else if (k < int'(apdg_pkg::OFS_INDEX)) b = seq[8*(k-4) +: 8];
      else if (k < int'(apdg_pkg::OFS_TSTAMP)) b = first_idx[8*(k-8) +: 8];
      else if (k == int'(apdg_pkg::OFS_FRAMES_L)) b = frames[7:0];
      else if (k == int'(apdg_pkg::OFS_FRAMES_H)) b = frames[15:8];
      else if (k == int'(apdg_pkg::OFS_CHANNELS)) b = chans;
      else if (k == int'(apdg_pkg::OFS_BPS)) b = bps;
      send_byte(b, nc && (k == 0));
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return apdg_pkg::SAT_POS_LIM;
      1: return apdg_pkg::SAT_NEG_LIM;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return 32'($urandom_range(4095));
      5: return -32'($urandom_range(4095));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) send_byte(w[8*k +: 8], 1'b0);
  endtask

  // full packet; bytes past frames*4 are filler
  task automatic send_packet(input logic [31:0] seq, input logic [63:0] first_idx,
                             input logic [15:0] frames, input logic [7:0] chans,
                             input logic [7:0] bps, input logic nc);
    int unsigned n;
    int unsigned sample_bytes;
    logic [31:0] w;
    n = frames * chans * bps;
    sample_bytes = frames * 4;
    w = '0;
    send_header(apdg_pkg::HDR_MAGIC, seq, first_idx, frames, chans, bps, nc,
                int'(apdg_pkg::HDR_LAST) + 1);
    for (int unsigned i = 0; i < n; i++) begin
      if (i[1:0] == 2'd0) w = pick_word();
      send_byte((i < sample_bytes) ? w[8*i[1:0] +: 8] : 8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic send_corner_packet(input logic [31:0] seq, input logic [63:0] first_idx);
    send_header(apdg_pkg::HDR_MAGIC, seq, first_idx, 16'd8, 8'd1, 8'd4, 1'b0,
                int'(apdg_pkg::HDR_LAST) + 1);
    foreach (corner_words[i]) send_word(corner_words[i]);
  endtask

  task automatic test_corner_samples();
    send_corner_packet(32'hFFFF_FFFF, 64'h8000_0000_0000_0000);
  endtask

  task automatic test_gain_extremes();
    logic [19:0] gains [4] = '{20'h80000, 20'h7FFFF, 20'hFFFFF, 20'd1};
    foreach (gains[i]) begin
      write_gain(gains[i]);
      send_corner_packet($urandom, {$urandom, $urandom});
    end
  endtask

  task automatic test_payload_shapes();
    send_packet(32'd10, 64'd100, 16'd2, 8'd1, 8'd4, 1'b0);   // sample on last byte
    send_packet(32'd11, 64'd200, 16'd2, 8'd2, 8'd4, 1'b0);   // filler after samples
    send_packet(32'd12, 64'd300, 16'd5, 8'd1, 8'd1, 1'b0);   // payload shorter than samples
    send_packet(32'd14, 64'd500, 16'd1, 8'd3, 8'd1, 1'b0);   // no whole sample at all
    send_packet(32'd15, 64'd600, 16'd64, 8'd1, 8'd1, 1'b0);  // sample bytes far above payload
  endtask

  task automatic test_empty_packets();
    send_packet(32'd20, 64'd1, 16'd0, 8'd2, 8'd2, 1'b0);
    send_packet(32'd21, 64'd2, 16'd4, 8'd0, 8'd2, 1'b0);
    send_packet(32'd22, 64'd3, 16'd4, 8'd2, 8'd0, 1'b0);
    send_packet(32'd24, 64'd5, 16'd1, 8'd1, 8'd4, 1'b0);
  endtask

  task automatic test_bad_magic();
    logic [31:0] bad [2] = '{32'hFFFF_FFFF, apdg_pkg::HDR_MAGIC ^ 32'h0001_0000};
    foreach (bad[i]) begin
      send_header(bad[i], 32'd30, 64'd7, 16'd2, 8'd1, 8'd4, i == 0,
                  int'(apdg_pkg::HDR_LAST) + 1);
      // a valid-looking header while halted must be ignored
      send_header(apdg_pkg::HDR_MAGIC, 32'd31, 64'd8, 16'd0, 8'd1, 8'd1, 1'b0,
                  int'(apdg_pkg::HDR_LAST) + 1);
      for (int k = 0; k < 5; k++) send_byte(8'($urandom_range(255)), 1'b0);
      send_packet(32'd32 + i, 64'd9, 16'd1, 8'd1, 8'd4, 1'b1);
    end
  endtask

  task automatic test_new_connection();
    send_header(apdg_pkg::HDR_MAGIC, 32'd40, 64'd1, 16'd2, 8'd1, 8'd4, 1'b0, 12);
    send_packet(32'd41, 64'd2, 16'd1, 8'd1, 8'd4, 1'b1);
    // restart right before the last header byte
    send_header(apdg_pkg::HDR_MAGIC, 32'd42, 64'd3, 16'd0, 8'd1, 8'd1, 1'b0,
                int'(apdg_pkg::HDR_LAST));
    send_packet(32'd43, 64'd4, 16'd1, 8'd1, 8'd4, 1'b1);
    // huge payload dropped part way through
    send_header(apdg_pkg::HDR_MAGIC, 32'd44, 64'd5, 16'hFFFF, 8'hFF, 8'hFF, 1'b0,
                int'(apdg_pkg::HDR_LAST) + 1);
    for (int k = 0; k < 10; k++) send_byte(8'($urandom_range(255)), 1'b0);
    send_packet(32'd45, 64'd6, 16'd2, 8'd1, 8'd4, 1'b1);
  endtask

  task automatic test_index_wrap();
    send_packet(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 16'd3, 8'd1, 8'd4, 1'b0);
    send_packet(32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 16'd1, 8'd1, 8'd4, 1'b0);
  endtask

  task automatic test_random_stream(input int tx_pct, input int rx_pct, input int n_bytes);
    int start;
    int roll;
    int unsigned n;
    logic resync;
    logic nc;
    logic [15:0] frames;
    logic [7:0] chans;
    logic [7:0] bps;
    logic [31:0] magic;
    write_gain(20'($urandom_range(20'hFFFFF)));
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = live_bytes;
    resync = 1'b1;
    while (live_bytes - start < n_bytes) begin
      roll = $urandom_range(99);
      nc = resync || ($urandom_range(3) == 0);
      frames = ($urandom_range(9) == 0) ? 16'($urandom_range(7, 40)) : 16'($urandom_range(6));
      chans = ($urandom_range(15) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
      bps = ($urandom_range(15) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
      if (roll < 70) begin
        send_packet($urandom, {$urandom, $urandom}, frames, chans, bps, nc);
        resync = 1'b0;
      end else if (roll < 80) begin
        magic = ($urandom_range(3) == 0) ? $urandom
                                         : apdg_pkg::HDR_MAGIC ^ (32'h1 << $urandom_range(31));
        send_header(magic, $urandom, {$urandom, $urandom}, frames, chans, bps, nc,
                    int'(apdg_pkg::HDR_LAST) + 1);
        repeat ($urandom_range(8)) send_byte(8'($urandom_range(255)), 1'b0);
        resync = 1'b1;
      end else if (roll < 90) begin
        // cut short in the header or in the payload, with any field values
        frames = 16'($urandom_range(16'hFFFF));
        chans = 8'($urandom_range(255));
        bps = 8'($urandom_range(255));
        send_header(apdg_pkg::HDR_MAGIC, $urandom, {$urandom, $urandom}, frames, chans,
                    bps, nc, $urandom_range(1, int'(apdg_pkg::HDR_LAST) + 1));
        n = frames * chans * bps;
        if (hdr_count == 0 && n > 1)
          repeat ($urandom_range(0, (n > 20) ? 20 : n - 1))
            send_byte(8'($urandom_range(255)), 1'b0);
        resync = 1'b1;
      end else if (roll < 95) begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
        resync = 1'b1;
      end else begin
        drain_results();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_samples();
    test_gain_extremes();
    test_payload_shapes();
    test_empty_packets();
    test_bad_magic();
    test_new_connection();
    test_index_wrap();
    test_random_stream(17, 86, 50);
    test_random_stream(86, 17, 50);
    test_random_stream(0, 0, 50);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- audio_packet_deframer_gain_core.f -----
hw/rtl/apdg_pkg.sv
hw/rtl/audio_packet_deframer_gain_core.sv
dv/audio_packet_deframer_gain_core_tb.sv
